/* hw/rtl/lprd_pkg.sv */
// Package for the length-prefixed record deframer.
// Holds the result kinds, op codes, queue word type and default sizes.
// No dependencies.
package lprd_pkg;

    localparam logic [2:0] KIND_RECORD        = 3'd0;
    localparam logic [2:0] KIND_COUNT         = 3'd1;
    localparam logic [2:0] KIND_BAD_LENGTH    = 3'd2;
    localparam logic [2:0] KIND_SHORT         = 3'd3;
    localparam logic [2:0] KIND_CLEAN_END     = 3'd4;
    localparam logic [2:0] KIND_PREMATURE_END = 3'd5;

    localparam logic [15:0] RESET_MAX_LEN = 16'h04FF;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [0:0] OP_DATA = 1'b0;
    localparam logic [0:0] OP_END  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
        logic [3:0] pkt_pos;
        logic       in_header;
    } lprd_entry_t;

endpackage

/* hw/rtl/length_prefixed_record_deframer_top.sv */
// Top level of the length-prefixed record deframer with its register port.
// Depends on lprd_pkg, lprd_front, lprd_fifo and lprd_back.
//
// The s_ channel carries one word per received byte: tdata is the byte,
// tlast marks the final byte of a packet and tuser[0] set means end of
// stream (tdata and tlast are then ignored). The first packet is the header;
// when it is nine bytes long its bytes 4 to 7 come out as the expected
// count. All later bytes form records, each a 4-byte little-endian length
// and a body, and every record yields one word on the m_ channel with its
// address and port. Errors and end of stream yield one final word and halt
// the block until reset.
// The block takes one word per cycle while the queue between the parsing
// front end and the back end has room; it absorbs short stalls. A word
// causing a result is queued and then registered before m_tvalid rises. A
// synchronous reset clears the parser and the queue and sets max_record_len
// to 1279. When the receiver holds m_tready low, the result register holds,
// and s_tready falls once the queue fills. max_record_len lies at byte
// address 0; the user must see it is written only while idle, unenforced.
module length_prefixed_record_deframer_top
    import lprd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,    // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // address[31:0], port[47:32], value[79:48]
    output logic [2:0]  m_tuser,    // kind[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] max_len_reg;
    logic        q_push, q_ready, q_valid, q_pop;
    lprd_entry_t q_in, q_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= RESET_MAX_LEN;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            max_len_reg <= pwdata[15:0];
        end
    end

    lprd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_ready  (q_ready),
        .q_data   (q_in)
    );

    lprd_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    lprd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .max_len  (max_len_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_out),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/lprd_front.sv */
// Front end of the deframer: accepts input words and tags each with its
// packet position and header phase. Depends on lprd_pkg.
module lprd_front
    import lprd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,
    output logic        q_push,
    input  logic        q_ready,
    output lprd_entry_t q_data
);

    logic [3:0] pkt_pos_reg, pkt_pos_next;
    logic       hdr_done_reg, hdr_done_next;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        q_data.op        = s_tuser[0];
        q_data.data_byte = s_tdata;
        q_data.last      = s_tlast;
        q_data.pkt_pos   = pkt_pos_reg;
        q_data.in_header = !hdr_done_reg;
    end

    always_comb begin
        pkt_pos_next  = pkt_pos_reg;
        hdr_done_next = hdr_done_reg;
        if (q_push && s_tuser[0] == OP_DATA) begin
            if (s_tlast) begin
                pkt_pos_next  = 4'd0;
                hdr_done_next = 1'b1;
            end else if (pkt_pos_reg != 4'd15) begin
                pkt_pos_next = pkt_pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_pos_reg  <= 4'd0;
            hdr_done_reg <= 1'b0;
        end else begin
            pkt_pos_reg  <= pkt_pos_next;
            hdr_done_reg <= hdr_done_next;
        end
    end

endmodule

/* hw/rtl/lprd_fifo.sv */
// Short queue between the front and back ends of the deframer.
// Depends on lprd_pkg for the queue word type.
module lprd_fifo
    import lprd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    output logic        push_ready,
    input  lprd_entry_t push_data,
    output logic        pop_valid,
    input  logic        pop,
    output lprd_entry_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lprd_entry_t     mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/lprd_back.sv */
// Back end of the deframer: parses header and records from queued words
// and holds the result register. Depends on lprd_pkg.
module lprd_back
    import lprd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] max_len,
    input  logic        q_valid,
    output logic        q_pop,
    input  lprd_entry_t q_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser
);

    logic        halted_reg, halted_next;
    logic [16:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] total_reg, total_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [15:0] out_port_reg, out_port_next;
    logic [31:0] out_value_reg, out_value_next;

    logic        fire;
    logic        short_pkt;
    logic        bad;
    logic        done;
    logic [16:0] idx;

    assign fire     = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = fire;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_value_reg, out_port_reg, out_addr_reg};

    always_comb begin
        halted_next    = halted_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_port_next  = out_port_reg;
        out_value_next = out_value_reg;
        short_pkt      = q_data.last && (q_data.pkt_pos < 4'd3);
        bad            = 1'b0;
        done           = 1'b0;
        idx            = pos_reg - 17'd4;

        if (fire && !halted_reg) begin
            if (q_data.op == OP_END) begin
                halted_next    = 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = (pos_reg != '0) ? KIND_PREMATURE_END : KIND_CLEAN_END;
                out_addr_next  = '0;
                out_port_next  = '0;
                out_value_next = total_reg;
            end else if (q_data.in_header) begin
                if (q_data.pkt_pos == 4'd0) begin
                    count_next = '0;
                end
                if (q_data.pkt_pos[3:2] == 2'b01) begin
                    count_next[8*q_data.pkt_pos[1:0] +: 8] = q_data.data_byte;
                end
                if (q_data.last && q_data.pkt_pos == 4'd8) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_COUNT;
                    out_addr_next  = '0;
                    out_port_next  = '0;
                    out_value_next = count_next;
                end
            end else begin
                if (pos_reg < 17'd4) begin
                    if (pos_reg == '0) begin
                        len_next  = '0;
                        addr_next = '0;
                        port_next = '0;
                    end
                    len_next[8*pos_reg[1:0] +: 8] = q_data.data_byte;
                    bad = (pos_reg == 17'd3) &&
                          (len_next == '0 || len_next > {16'd0, max_len});
                end else begin
                    if (idx < 17'd4) begin
                        addr_next[8*(2'd3 - idx[1:0]) +: 8] = q_data.data_byte;
                    end else if (idx == 17'd4) begin
                        port_next[7:0] = q_data.data_byte;
                    end else if (idx == 17'd5) begin
                        port_next[15:8] = q_data.data_byte;
                    end
                    done = ({15'd0, idx} + 32'd1) == len_reg;
                end

                if (short_pkt) begin
                    halted_next    = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SHORT;
                    out_addr_next  = '0;
                    out_port_next  = '0;
                    out_value_next = '0;
                end else if (bad) begin
                    halted_next    = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_BAD_LENGTH;
                    out_addr_next  = '0;
                    out_port_next  = '0;
                    out_value_next = '0;
                end else if (done) begin
                    pos_next       = '0;
                    total_next     = (total_reg != 32'hFFFF_FFFF) ? total_reg + 32'd1
                                                                  : total_reg;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_RECORD;
                    out_addr_next  = addr_next;
                    out_port_next  = port_next;
                    out_value_next = '0;
                end else begin
                    pos_next = pos_reg + 17'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg    <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            halted_reg    <= halted_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg       <= len_next;
        addr_reg      <= addr_next;
        port_reg      <= port_next;
        count_reg     <= count_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_port_reg  <= out_port_next;
        out_value_reg <= out_value_next;
    end

endmodule

/* tb/tb_length_prefixed_record_deframer_top.sv */
// Self-checking testbench for length_prefixed_record_deframer_top.
// Drives a header and length-prefixed records on the s_ stream, predicts every m_ word,
// and reprograms max_record_len between phases. Depends on lprd_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_length_prefixed_record_deframer_top;
    import lprd_pkg::*;

    localparam logic [2:0] REG_MAX_RECORD_LEN = 3'd0;
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam int FILL_CHECKER = 3;
    localparam int STREAM_WORDS = 2000;
    localparam int MAX_PRINTED  = 100;

    typedef enum int {PKT_NATURAL, PKT_PREFER, PKT_NEVER, PKT_FORCE} pkt_end_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
    } stream_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] value;
    } deframe_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = OP_DATA;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    length_prefixed_record_deframer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stream_word_t    byte_stream[$];
    deframe_result_t predicted_results[$];
    stream_word_t    taken_word;
    deframe_result_t want;

    int   error_count = 0;
    int   cycle_count = 0;
    int   words_queued = 0;
    int   words_accepted = 0;
    int   results_seen = 0;
    int   records_seen = 0;
    int   settings_used = 0;
    int   gen_pkt_count = 0;
    logic word_taken = 1'b0;
    logic calm;

    logic [15:0] p_max_len = RESET_MAX_LEN;
    logic        p_halted = 1'b0;
    logic        p_header_done = 1'b0;
    logic [3:0]  p_packet_count = 4'd0;
    logic [16:0] p_record_pos = 17'd0;
    logic [31:0] p_record_len = 32'd0;
    logic [31:0] p_address = 32'd0;
    logic [15:0] p_port = 16'd0;
    logic [31:0] p_count = 32'd0;
    logic [31:0] p_records = 32'd0;

    assign calm = (cycle_count >= 1000) && (cycle_count < 2500);

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_failure(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic expect_result(input logic [2:0] kind, input logic [31:0] address,
                                 input logic [15:0] port, input logic [31:0] value);
        deframe_result_t r;
        r.kind = kind;
        r.address = address;
        r.port = port;
        r.value = value;
        predicted_results.push_back(r);
    endtask

    task automatic predict_deframe(input logic op, input logic [7:0] b, input logic last);
        int pb, npb, pos, idx;
        logic [31:0] wide;
        logic bad, done;
        bad = 1'b0;
        done = 1'b0;
        wide = {24'd0, b};
        if (p_halted)
            return;
        if (op == OP_END) begin
            p_halted = 1'b1;
            expect_result((p_record_pos != 0) ? KIND_PREMATURE_END : KIND_CLEAN_END,
                          32'd0, 16'd0, p_records);
            return;
        end
        pb = p_packet_count;
        npb = (pb < 15) ? pb + 1 : 15;
        if (!p_header_done) begin
            if (pb == 0)
                p_count = 32'd0;
            if (pb >= 4 && pb <= 7)
                p_count = p_count | (wide << (8 * (pb - 4)));
            if (last) begin
                p_header_done = 1'b1;
                p_packet_count = 4'd0;
                if (npb == 9)
                    expect_result(KIND_COUNT, 32'd0, 16'd0, p_count);
            end else begin
                p_packet_count = npb[3:0];
            end
            return;
        end
        pos = p_record_pos;
        if (pos < 4) begin
            if (pos == 0) begin
                p_record_len = 32'd0;
                p_address = 32'd0;
                p_port = 16'd0;
            end
            p_record_len = p_record_len | (wide << (8 * pos));
            pos++;
            if (pos == 4 && (p_record_len == 0 || p_record_len > p_max_len))
                bad = 1'b1;
        end else begin
            idx = pos - 4;
            if (idx < 4)
                p_address = p_address | (wide << (8 * (3 - idx)));
            else if (idx == 4)
                p_port = p_port | {8'd0, b};
            else if (idx == 5)
                p_port = p_port | {b, 8'd0};
            pos++;
            if (idx + 1 == p_record_len)
                done = 1'b1;
        end
        if (last && npb < 4) begin
            p_halted = 1'b1;
            expect_result(KIND_SHORT, 32'd0, 16'd0, 32'd0);
            return;
        end
        if (bad) begin
            p_halted = 1'b1;
            expect_result(KIND_BAD_LENGTH, 32'd0, 16'd0, 32'd0);
            return;
        end
        p_packet_count = last ? 4'd0 : npb[3:0];
        if (done) begin
            p_record_pos = 17'd0;
            if (p_records != 32'hFFFF_FFFF)
                p_records = p_records + 32'd1;
            expect_result(KIND_RECORD, p_address, p_port, 32'd0);
            return;
        end
        p_record_pos = pos[16:0];
    endtask

    task automatic push_raw(input logic op, input logic [7:0] b, input logic last);
        stream_word_t w;
        w.op = op;
        w.data_byte = b;
        w.last = last;
        byte_stream.push_back(w);
    endtask

    task automatic push_byte(input logic [7:0] b, input pkt_end_t mode);
        int n;
        logic last;
        n = gen_pkt_count + 1;
        case (mode)
            PKT_FORCE:  last = 1'b1;
            PKT_NEVER:  last = 1'b0;
            PKT_PREFER: last = (n >= 4);
            default:    last = (n >= 4) && (($urandom_range(0, 9) == 0) || (n >= 40));
        endcase
        push_raw(OP_DATA, b, last);
        gen_pkt_count = last ? 0 : n;
        words_queued++;
    endtask

    task automatic push_end();
        push_raw(OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        words_queued++;
    endtask

    task automatic push_record(input logic [31:0] len, input int fill, input pkt_end_t tail);
        int i;
        logic [7:0] b;
        for (i = 0; i < 4; i++)
            push_byte(len[8*i +: 8], PKT_NATURAL);
        for (i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO:    b = 8'h00;
                FILL_ONES:    b = 8'hFF;
                FILL_CHECKER: b = i[0] ? 8'h5A : 8'hA5;
                default:      b = 8'($urandom_range(0, 255));
            endcase
            push_byte(b, (i == len - 1) ? tail : PKT_NATURAL);
        end
    endtask

    function automatic logic [31:0] pick_record_len();
        int r, len;
        r = $urandom_range(0, 99);
        if (r < 10 && p_max_len <= 300)
            return {16'd0, p_max_len};
        if (r < 70)
            len = $urandom_range(1, 12);
        else if (r < 95)
            len = $urandom_range(1, 64);
        else if (r < 99)
            len = $urandom_range(1, 300);
        else
            len = $urandom_range(1, 1500);
        if (len > p_max_len)
            len = $urandom_range(1, p_max_len);
        return len;
    endfunction

    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_max_len(input logic [15:0] want_len);
        logic [31:0] got;
        apb_transfer(1'b0, REG_MAX_RECORD_LEN, 32'd0, got);
        if (got !== {16'd0, want_len})
            report_failure($sformatf("max_record_len reads 0x%0h, expected 0x%0h",
                                     got, want_len));
    endtask

    task automatic settle_idle();
        while (byte_stream.size() != 0 || predicted_results.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic change_setting(input logic [15:0] len_limit);
        logic [31:0] unused;
        settle_idle();
        apb_transfer(1'b1, REG_MAX_RECORD_LEN, {16'd0, len_limit}, unused);
        p_max_len = len_limit;
        settings_used++;
        check_max_len(len_limit);
    endtask

    // Ends the current packet on a record boundary so that a short packet can follow.
    task automatic close_packet();
        while (gen_pkt_count != 0)
            push_record(32'd1, FILL_RANDOM, PKT_PREFER);
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        word_taken = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            word_taken = 1'b1;
            taken_word = byte_stream.pop_front();
            predict_deframe(taken_word.op, taken_word.data_byte, taken_word.last);
            words_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_taken) begin
            s_tvalid <= 1'b1;
        end else if (byte_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
            s_tvalid <= 1'b1;
            s_tdata <= byte_stream[0].data_byte;
            s_tlast <= byte_stream[0].last;
            s_tuser <= byte_stream[0].op;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser == KIND_RECORD)
                records_seen++;
            if (predicted_results.size() == 0) begin
                report_failure($sformatf("unexpected result word kind %0d", m_tuser));
            end else begin
                want = predicted_results.pop_front();
                if (m_tuser !== want.kind)
                    report_failure($sformatf("word %0d kind %0d, expected %0d",
                                             results_seen, m_tuser, want.kind));
                if (m_tdata[31:0] !== want.address)
                    report_failure($sformatf("word %0d address 0x%0h, expected 0x%0h",
                                             results_seen, m_tdata[31:0], want.address));
                if (m_tdata[47:32] !== want.port)
                    report_failure($sformatf("word %0d port 0x%0h, expected 0x%0h",
                                             results_seen, m_tdata[47:32], want.port));
                if (m_tdata[79:48] !== want.value)
                    report_failure($sformatf("word %0d value 0x%0h, expected 0x%0h",
                                             results_seen, m_tdata[79:48], want.value));
            end
        end
    end

    initial begin
        int ending, hdr_len, i, k, phase_end, guard;
        logic [15:0] setting;
        logic [31:0] len;
        string ending_name;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_max_len(RESET_MAX_LEN);

        ending = $urandom_range(0, 19);
        if (ending == 0) begin
            ending_name = "end of stream before the header closed";
            k = $urandom_range(0, 8);
            for (i = 0; i < k; i++)
                push_byte(8'($urandom_range(0, 255)), PKT_NEVER);
            push_end();
        end else begin
            hdr_len = ($urandom_range(0, 3) != 0) ? 9 : $urandom_range(1, 24);
            for (i = 1; i < hdr_len; i++)
                push_byte(8'($urandom_range(0, 255)), PKT_NEVER);
            push_byte(8'($urandom_range(0, 255)), PKT_FORCE);

            push_record(32'd1, FILL_ZERO, PKT_NATURAL);
            push_record(32'd2, FILL_ONES, PKT_NATURAL);
            push_record(32'd4, FILL_CHECKER, PKT_NATURAL);
            push_record(32'd5, FILL_RANDOM, PKT_NATURAL);
            push_record(32'd6, FILL_ONES, PKT_NATURAL);
            push_record(32'd7, FILL_ZERO, PKT_NATURAL);

            change_setting(16'd1);
            for (i = 0; i < 15; i++)
                push_record(32'd1, FILL_RANDOM, PKT_NATURAL);
            change_setting(16'hFFFF);
            for (i = 0; i < 30; i++)
                push_record(pick_record_len(), FILL_RANDOM, PKT_NATURAL);

            while (words_queued < STREAM_WORDS) begin
                case ($urandom_range(0, 5))
                    0:       setting = 16'd1;
                    1:       setting = 16'hFFFF;
                    2:       setting = 16'($urandom_range(2, 8));
                    3:       setting = RESET_MAX_LEN;
                    default: setting = 16'($urandom_range(1, 65535));
                endcase
                change_setting(setting);
                phase_end = words_queued + $urandom_range(150, 350);
                while (words_queued < phase_end && words_queued < STREAM_WORDS)
                    push_record(pick_record_len(),
                                ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                            : FILL_RANDOM,
                                PKT_NATURAL);
            end

            if (ending <= 5) begin
                ending_name = "a bad record length";
                case ($urandom_range(0, 2))
                    0:       len = 32'd0;
                    1:       len = {16'd0, p_max_len} + 32'd1;
                    default: len = $urandom | 32'h0001_0000;
                endcase
                for (i = 0; i < 4; i++)
                    push_byte(len[8*i +: 8], PKT_NATURAL);
            end else if (ending <= 10) begin
                ending_name = "a short packet";
                close_packet();
                if (p_max_len >= 2 && $urandom_range(0, 1) == 1) begin
                    // The short packet carries the final body byte of a record.
                    for (i = 0; i < 4; i++)
                        push_byte((i == 0) ? 8'd2 : 8'd0, PKT_NEVER);
                    push_byte(8'($urandom_range(0, 255)), PKT_PREFER);
                    push_byte(8'($urandom_range(0, 255)), PKT_FORCE);
                end else begin
                    k = $urandom_range(1, 3);
                    for (i = 1; i <= k; i++)
                        push_byte(8'($urandom_range(0, 255)), (i == k) ? PKT_FORCE : PKT_NEVER);
                end
            end else if (ending <= 14) begin
                ending_name = "a partly received record";
                len = pick_record_len();
                if (len < 2 || $urandom_range(0, 1) == 1) begin
                    k = $urandom_range(1, 3);
                    for (i = 0; i < k; i++)
                        push_byte(len[8*i +: 8], PKT_NATURAL);
                end else begin
                    for (i = 0; i < 4; i++)
                        push_byte(len[8*i +: 8], PKT_NATURAL);
                    k = $urandom_range(0, len - 1);
                    for (i = 0; i < k; i++)
                        push_byte(8'($urandom_range(0, 255)), PKT_NATURAL);
                end
                push_end();
            end else begin
                ending_name = "a clean end of stream";
                push_end();
            end
        end

        // The block is halted now; these words must be swallowed without results.
        for (i = 0; i < 8; i++)
            push_raw(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));

        while (byte_stream.size() != 0 || s_tvalid)
            @(posedge aclk);
        guard = 0;
        while (predicted_results.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (predicted_results.size() != 0)
            report_failure($sformatf("%0d expected result words never arrived",
                                     predicted_results.size()));

        $display("Run covered %0d accepted input words and %0d result words, %0d of them records.",
                 words_accepted, results_seen, records_seen);
        $display("It used %0d max_record_len settings and closed with %s.",
                 settings_used, ending_name);
        if (error_count == 0) begin
            $display("length_prefixed_record_deframer_top regression: pass");
        end else begin
            $display("length_prefixed_record_deframer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("length_prefixed_record_deframer_top regression: fail");
        $finish;
    end

endmodule

/* length_prefixed_record_deframer_top.f */
hw/rtl/lprd_pkg.sv
hw/rtl/lprd_front.sv
hw/rtl/lprd_fifo.sv
hw/rtl/lprd_back.sv
hw/rtl/length_prefixed_record_deframer_top.sv
tb/tb_length_prefixed_record_deframer_top.sv
